FILE: sv/mbp_pkg.sv
// Package for the MSB-first bit packer: shared constants and the sequencer state type.
// Depends on nothing; the interfaces and the core use it.

package mbp_pkg;

  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int BYTE_W            = 8;
  localparam int INDEX_W           = 32;
  localparam int VALUE_W           = 32;
  localparam int LEN_W             = 6;

  localparam logic [BYTE_W-1:0] ALL_ONES_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;

  localparam logic ACT_PUT   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SETTLE
  } state_t;

endpackage

FILE: sv/mbp_if.sv
// Valid/ready channel interfaces for the bit packer: request channel and byte channel.
// Depends on mbp_pkg for field widths.

interface mbp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [mbp_pkg::VALUE_W-1:0]        code_value;
  logic [mbp_pkg::LEN_W-1:0]          code_length;

  modport source (output valid, action, code_value, code_length, input ready);
  modport sink   (input valid, action, code_value, code_length, output ready);
endinterface

interface mbp_out_if;
  logic                               valid;
  logic                               ready;
  logic [mbp_pkg::BYTE_W-1:0]         out_byte;
  logic [mbp_pkg::INDEX_W-1:0]        byte_index;
  logic                               last;

  modport source (output valid, out_byte, byte_index, last, input ready);
  modport sink   (input valid, out_byte, byte_index, last, output ready);
endinterface

FILE: sv/msb_first_bit_packer_core.sv
// MSB-first bit packer: appends variable-length codes to a byte stream.
// Depends on mbp_pkg and the channel interfaces in mbp_if.sv.
//
// Usage:
//   in_ch  carries requests: action 0 appends the low code_length bits of
//          code_value (length saturates to MAX_CODE_BITS), action 1 pads a
//          partly filled byte with one-bits and emits it, followed by a
//          0x00 stuff byte when the padded byte is 0xFF.
//   out_ch carries completed bytes with their running stream index; last
//          marks the final byte caused by a request.
// Timing: a request is taken only when the sequencer is idle. The code is
//   aligned by one barrel shift on acceptance; a shift register then hands
//   out one byte per cycle unless out_ch stalls. A request runs idle, emit
//   (per byte, skipped if none) and settle, then idle again before the next
//   request is taken. In the emit state each byte moves from the shift
//   register to the output register once that register is free.
// Reset (rst_n low, synchronous): empties the partial byte, zeroes the
//   byte index and drops any pending output byte.
// Stall: a byte waits in the output register while out_ch.ready is low and
//   the sequencer holds; no byte is lost or repeated.

module msb_first_bit_packer_core #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  mbp_in_if.sink         in_ch,
  mbp_out_if.source      out_ch
);

  localparam int ACC_W = MAX_CODE_BITS + mbp_pkg::BYTE_W;
  localparam int SH_W  = $clog2(ACC_W + 1);
  localparam int CNT_W = $clog2(ACC_W / mbp_pkg::BYTE_W + 3);
  localparam logic [mbp_pkg::LEN_W-1:0] MAX_LEN = mbp_pkg::LEN_W'(MAX_CODE_BITS);

  mbp_pkg::state_t state_r, state_nxt;

  logic [ACC_W-1:0]              acc_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [2:0]                    rem_r;
  logic [mbp_pkg::BYTE_W-1:0]    partial_r;
  logic [2:0]                    held_r;
  logic [mbp_pkg::INDEX_W-1:0]   byte_count_r;
  logic                          out_valid_r;
  logic [mbp_pkg::BYTE_W-1:0]    out_byte_r;
  logic [mbp_pkg::INDEX_W-1:0]   out_index_r;
  logic                          out_last_r;

  logic                          in_fire;
  logic                          emit_fire;
  logic [mbp_pkg::LEN_W-1:0]     len_sat;
  logic [ACC_W-1:0]              val_w;
  logic [ACC_W-1:0]              val_m;
  logic [SH_W-1:0]               total;
  logic [SH_W-1:0]               sh_amt;
  logic [mbp_pkg::BYTE_W-1:0]    pad_byte;
  logic [ACC_W-1:0]              acc_load;
  logic [CNT_W-1:0]              cnt_load;
  logic [2:0]                    rem_load;

  // Load path: saturate, mask and left-align the code behind the held bits, or pad them for a flush
  always_comb begin
    len_sat = (in_ch.code_length > MAX_LEN) ? MAX_LEN : in_ch.code_length;
    val_w   = ACC_W'(in_ch.code_value);
    for (int i = 0; i < ACC_W; i++) begin
      val_m[i] = val_w[i] & (i < int'(len_sat));
    end
    total    = SH_W'(held_r) + SH_W'(len_sat);
    sh_amt   = SH_W'(ACC_W) - total;
    pad_byte = partial_r | (mbp_pkg::ALL_ONES_BYTE >> held_r);

    if (in_ch.action == mbp_pkg::ACT_FLUSH) begin
      acc_load = {pad_byte, (ACC_W - mbp_pkg::BYTE_W)'(0)};
      rem_load = 3'd0;
      if (held_r == 3'd0) begin
        // nothing waiting: keep the empty byte
        acc_load = '0;
        cnt_load = '0;
      end else if (pad_byte == mbp_pkg::ALL_ONES_BYTE) begin
        cnt_load = CNT_W'(2);
      end else begin
        cnt_load = CNT_W'(1);
      end
    end else begin
      acc_load = {partial_r, (ACC_W - mbp_pkg::BYTE_W)'(0)} | (val_m << sh_amt);
      cnt_load = CNT_W'(total >> 3);
      rem_load = total[2:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (cnt_load == '0) ? mbp_pkg::ST_SETTLE : mbp_pkg::ST_EMIT;
        end
      end
      mbp_pkg::ST_EMIT: begin
        if (emit_fire && cnt_r == CNT_W'(1)) begin
          state_nxt = mbp_pkg::ST_SETTLE;
        end
      end
      mbp_pkg::ST_SETTLE: state_nxt = mbp_pkg::ST_IDLE;
      default:            state_nxt = mbp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = (state_r == mbp_pkg::ST_IDLE);
    in_fire     = in_ch.valid && in_ch.ready;
    emit_fire   = (state_r == mbp_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mbp_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      partial_r    <= '0;
      held_r       <= 3'd0;
      byte_count_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (in_fire) begin
        acc_r <= acc_load;
        cnt_r <= cnt_load;
        rem_r <= rem_load;
      end

      // advance: top byte to the output register, shift the rest up
      if (emit_fire) begin
        out_valid_r  <= 1'b1;
        out_byte_r   <= acc_r[ACC_W-1 -: mbp_pkg::BYTE_W];
        out_index_r  <= byte_count_r;
        out_last_r   <= (cnt_r == CNT_W'(1));
        acc_r        <= acc_r << mbp_pkg::BYTE_W;
        cnt_r        <= cnt_r - CNT_W'(1);
        byte_count_r <= byte_count_r + mbp_pkg::INDEX_W'(1);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // leftover bits sit at the top with zeros below
      if (state_r == mbp_pkg::ST_SETTLE) begin
        partial_r <= acc_r[ACC_W-1 -: mbp_pkg::BYTE_W];
        held_r    <= rem_r;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_index = out_index_r;
  assign out_ch.last       = out_last_r;

  a_emit_from_sequencer: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> $past(state_r) == mbp_pkg::ST_IDLE || $past(state_r) == mbp_pkg::ST_EMIT)
    else $error("byte emitted outside the emit sequence");

  a_emit_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mbp_pkg::ST_EMIT |-> cnt_r != '0)
    else $error("emit state with no bytes left");

  a_settle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mbp_pkg::ST_SETTLE |-> cnt_r == '0)
    else $error("settle reached with bytes still queued");

  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r & (mbp_pkg::ALL_ONES_BYTE >> held_r)) == '0)
    else $error("free bits of the partial byte are not zero");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("request taken while sequencer busy");

endmodule

FILE: tb/sv/msb_first_bit_packer_core_checker.sv
`timescale 1ns / 100ps
// Byte stream checker for the MSB-first bit packer: tracks packer state per request,
// queues the bytes each request should produce and compares them with the byte channel.
// Depends on mbp_pkg and the channel interfaces in mbp_if.sv.

module mbp_byte_checker #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mbp_in_if    in_ch,
  mbp_out_if   out_ch,
  output int   mismatch_count,
  output int   bytes_pending
);

  typedef struct {
    logic [mbp_pkg::BYTE_W-1:0]  data;
    logic [mbp_pkg::INDEX_W-1:0] index;
    logic                        last;
  } stream_byte_t;

  stream_byte_t                expected_bytes[$];
  logic [mbp_pkg::BYTE_W-1:0]  partial_byte;
  int                          free_bits;
  logic [mbp_pkg::INDEX_W-1:0] byte_count;
  int                          errors = 0;

  function automatic void queue_byte(input logic [mbp_pkg::BYTE_W-1:0] data);
    stream_byte_t b;
    b.data  = data;
    b.index = byte_count;
    b.last  = 1'b0;
    expected_bytes.push_back(b);
    byte_count = byte_count + mbp_pkg::INDEX_W'(1);
  endfunction

  // Work out the bytes one request completes and advance the packer state.
  function automatic void pack_request(input logic act,
                                       input logic [mbp_pkg::VALUE_W-1:0] val,
                                       input logic [mbp_pkg::LEN_W-1:0] len);
    logic [63:0]                acc;
    logic [mbp_pkg::BYTE_W-1:0] pad_byte;
    stream_byte_t               tail;
    int                         used;
    int                         total;
    int                         start;
    start = expected_bytes.size();
    if (act == mbp_pkg::ACT_FLUSH) begin
      if (free_bits < mbp_pkg::BYTE_W) begin
        pad_byte = partial_byte | ((8'd1 << free_bits) - 8'd1);
        queue_byte(pad_byte);
        if (pad_byte == mbp_pkg::ALL_ONES_BYTE)
          queue_byte(mbp_pkg::STUFF_BYTE);
        partial_byte = '0;
        free_bits    = mbp_pkg::BYTE_W;
      end
    end else begin
      used = (int'(len) > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(len);
      if (used > 0) begin
        acc = {32'd0, val};
        if (used < 64)
          acc &= (64'd1 << used) - 64'd1;
        acc |= {56'd0, partial_byte >> free_bits} << used;
        total = mbp_pkg::BYTE_W - free_bits + used;
        while (total >= mbp_pkg::BYTE_W) begin
          queue_byte(8'(acc >> (total - mbp_pkg::BYTE_W)));
          total -= mbp_pkg::BYTE_W;
        end
        partial_byte = 8'((acc & ((64'd1 << total) - 64'd1)) << (mbp_pkg::BYTE_W - total));
        free_bits    = mbp_pkg::BYTE_W - total;
      end
    end
    // mark the final byte of this request
    if (expected_bytes.size() > start) begin
      tail      = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  function automatic void check_byte();
    stream_byte_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected byte %h at index %0d", out_ch.out_byte, out_ch.byte_index);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    if (out_ch.out_byte !== want.data) begin
      $error("out_byte: expected %h, actual %h", want.data, out_ch.out_byte);
      errors++;
    end
    if (out_ch.byte_index !== want.index) begin
      $error("byte_index: expected %0d, actual %0d", want.index, out_ch.byte_index);
      errors++;
    end
    if (out_ch.last !== want.last) begin
      $error("last: expected %b, actual %b", want.last, out_ch.last);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      partial_byte = '0;
      free_bits    = mbp_pkg::BYTE_W;
      byte_count   = '0;
      expected_bytes.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        pack_request(in_ch.action, in_ch.code_value, in_ch.code_length);
      if (out_ch.valid && out_ch.ready)
        check_byte();
    end
    mismatch_count <= errors;
    bytes_pending  <= expected_bytes.size();
  end

endmodule

FILE: tb/sv/msb_first_bit_packer_core_tb.sv
`timescale 1ns / 100ps
// Top of the bit packer testbench: clock, reset, request stimulus, byte channel stalls,
// watchdog and verdict. Depends on mbp_pkg, mbp_if.sv, the core and mbp_byte_checker.

module msb_first_bit_packer_core_tb;

  localparam int IDLE_LIMIT     = 2000;
  localparam int ITEMS_PER_MODE = 87;
  localparam int DRAIN_CYCLES   = 16;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   mismatch_count;
  int   bytes_pending;

  mbp_in_if  in_ch();
  mbp_out_if out_ch();

  msb_first_bit_packer_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mbp_byte_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte channel back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // end the run once nothing has moved on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic send_request(input logic act, input logic [mbp_pkg::VALUE_W-1:0] val,
                              input logic [mbp_pkg::LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.code_value  <= val;
    in_ch.code_length <= len;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic put_code(input logic [mbp_pkg::VALUE_W-1:0] val,
                          input logic [mbp_pkg::LEN_W-1:0] len);
    send_request(mbp_pkg::ACT_PUT, val, len);
  endtask

  task automatic flush_byte();
    send_request(mbp_pkg::ACT_FLUSH, $urandom(), mbp_pkg::LEN_W'($urandom_range(63)));
  endtask

  task automatic random_request();
    logic [mbp_pkg::VALUE_W-1:0] val;
    int                          pick;
    pick = $urandom_range(99);
    if (pick < 20)
      val = '1;
    else if (pick < 30)
      val = '0;
    else
      val = $urandom();
    pick = $urandom_range(99);
    if (pick < 15)
      flush_byte();
    else if (pick < 20)
      put_code(val, '0);
    else if (pick < 27)
      put_code(val, mbp_pkg::LEN_W'($urandom_range(63, 33)));
    else if (pick < 45)
      put_code(val, mbp_pkg::LEN_W'($urandom_range(32, 17)));
    else
      put_code(val, mbp_pkg::LEN_W'($urandom_range(16, 1)));
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= mbp_pkg::ACT_PUT;
    in_ch.code_value  <= '0;
    in_ch.code_length <= '0;
    send_idle_pct = 16;
    recv_idle_pct = 61;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    flush_byte();                          // nothing waiting: no byte
    put_code(32'hFFFF_FFFF, 6'd0);         // zero length
    put_code(32'hFFFF_FFFF, 6'd32);        // four full bytes
    put_code(32'h0000_0001, 6'd1);
    flush_byte();                          // pads to all ones, then stuffs
    put_code(32'hFFFF_FFF2, 6'd3);         // value wider than its length
    flush_byte();
    put_code(32'h1234_5678, 6'd33);        // length saturates
    put_code(32'hA5C3_0F96, 6'd63);
    put_code(32'h0000_007F, 6'd7);
    flush_byte();
    put_code(32'h0000_0000, 6'd8);
    put_code(32'hFFFF_FFF0, 6'd4);
    put_code(32'h0000_000F, 6'd4);
    put_code(32'h0000_0000, 6'd5);
    put_code(32'h0000_0000, 6'd32);        // straddles with five bits waiting
    put_code(32'h5555_5555, 6'd31);
    flush_byte();
    put_code(32'h0000_0000, 6'd7);
    flush_byte();                          // single pad bit
    put_code(32'hDEAD_BEEF, 6'd16);
    flush_byte();                          // nothing waiting after a whole byte

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_MODE) random_request();
    end
    in_ch.valid <= 1'b0;

    // drain what is still in flight
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && bytes_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
